@@ hw/rtl/integer_to_roman_numeral_encoder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Roman numeral encoder
// Clocked, reset-qualified implication checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ROMAN_NUMERAL_ENCODER_ASSERT_SVH
`define INTEGER_TO_ROMAN_NUMERAL_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define I2R_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define I2R_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/i2r_enc_pkg.sv @@
// ----------------------------------------------------------------------------
// i2r_enc_pkg
// Types, constants and symbol tables shared by the Roman numeral encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package i2r_enc_pkg;

  localparam int unsigned ValueW = 12;
  localparam int unsigned CharW  = 7;
  localparam int unsigned DigitW = 4;
  localparam int unsigned IdxW   = 2;  // symbol index inside one digit, 0..3
  localparam int unsigned LenW   = 3;  // symbols per digit, 0..4
  localparam int unsigned PosW   = 2;  // decimal position, units = 0
  localparam int unsigned ScaleW = 14; // holds 9 * 1000

  localparam logic [ValueW-1:0] MaxValid = ValueW'(3999);
  localparam logic [PosW-1:0]   PosTop   = PosW'(3);
  localparam int unsigned       MaxDigit = 9;

  // ASCII codes
  localparam logic [CharW-1:0] ChNone = 7'h00;
  localparam logic [CharW-1:0] ChI    = 7'h49;
  localparam logic [CharW-1:0] ChV    = 7'h56;
  localparam logic [CharW-1:0] ChX    = 7'h58;
  localparam logic [CharW-1:0] ChL    = 7'h4C;
  localparam logic [CharW-1:0] ChC    = 7'h43;
  localparam logic [CharW-1:0] ChD    = 7'h44;
  localparam logic [CharW-1:0] ChM    = 7'h4D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    KIND_UNIT,
    KIND_FIVE,
    KIND_TEN
  } kind_e;

  typedef struct packed {
    logic load;      // take value, start at thousands
    logic push_err;  // write the out-of-range word
    logic extract;   // split off the current digit
    logic next_pos;  // step down one decimal position
    logic push_sym;  // write one symbol word
    logic next_sym;  // advance symbol index
  } ctrl_cmd_t;

  typedef struct packed {
    logic range_err;
    logic digit_zero;
    logic sym_last;
    logic rest_zero;
    logic out_free;
  } dp_sts_t;

  // k * 10^pos
  function automatic logic [ScaleW-1:0] digit_scale(logic [PosW-1:0] pos,
                                                    logic [DigitW-1:0] k);
    logic [ScaleW-1:0] base;
    unique case (pos)
      2'd0:    base = ScaleW'(1);
      2'd1:    base = ScaleW'(10);
      2'd2:    base = ScaleW'(100);
      default: base = ScaleW'(1000);
    endcase
    return ScaleW'(base * ScaleW'(k));
  endfunction

  function automatic logic [LenW-1:0] digit_len(logic [DigitW-1:0] d);
    logic [LenW-1:0] len;
    unique case (d)
      4'd1, 4'd5:              len = LenW'(1);
      4'd2, 4'd4, 4'd6, 4'd9:  len = LenW'(2);
      4'd3, 4'd7:              len = LenW'(3);
      4'd8:                    len = LenW'(4);
      default:                 len = LenW'(0);
    endcase
    return len;
  endfunction

  function automatic kind_e sym_kind(logic [DigitW-1:0] d, logic [IdxW-1:0] idx);
    kind_e kind;
    if (d == 4'd9) begin
      kind = (idx == '0) ? KIND_UNIT : KIND_TEN;
    end else if (d == 4'd4) begin
      kind = (idx == '0) ? KIND_UNIT : KIND_FIVE;
    end else if (d >= 4'd5) begin
      kind = (idx == '0) ? KIND_FIVE : KIND_UNIT;
    end else begin
      kind = KIND_UNIT;
    end
    return kind;
  endfunction

  function automatic logic [CharW-1:0] sym_char(logic [PosW-1:0] pos, kind_e kind);
    logic [CharW-1:0] ch;
    unique case (pos)
      2'd0: ch = (kind == KIND_UNIT) ? ChI : (kind == KIND_FIVE) ? ChV : ChX;
      2'd1: ch = (kind == KIND_UNIT) ? ChX : (kind == KIND_FIVE) ? ChL : ChC;
      2'd2: ch = (kind == KIND_UNIT) ? ChC : (kind == KIND_FIVE) ? ChD : ChM;
      default: ch = (kind == KIND_UNIT) ? ChM : ChNone;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/i2r_enc_ctrl.sv @@
// ----------------------------------------------------------------------------
// i2r_enc_ctrl
// Sequencer: accept, per-digit extract, per-symbol emit.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_enc_ctrl
  import i2r_enc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (sts_i.range_err) begin
          if (sts_i.out_free) state_d = ST_IDLE;
        end else if (!sts_i.digit_zero) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.sym_last) begin
          state_d = sts_i.rest_zero ? ST_IDLE : ST_DIGIT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DIGIT: begin
        cmd_o.push_err = sts_i.range_err && sts_i.out_free;
        cmd_o.extract  = !sts_i.range_err;
        cmd_o.next_pos = !sts_i.range_err && sts_i.digit_zero;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.push_sym = 1'b1;
          cmd_o.next_pos = sts_i.sym_last && !sts_i.rest_zero;
          cmd_o.next_sym = !sts_i.sym_last;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/i2r_enc_dp.sv @@
// ----------------------------------------------------------------------------
// i2r_enc_dp
// Remainder, digit and symbol registers plus the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_enc_dp
  import i2r_enc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ValueW-1:0] value_i,
  input  ctrl_cmd_t         cmd_i,
  output dp_sts_t           sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CharW-1:0]  symbol_char_o,
  output logic              last_symbol_o,
  output logic              out_of_range_o
);

  logic [ValueW-1:0] rem_q, rem_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [DigitW-1:0] digit_q, digit_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  char_q, char_d;
  logic              last_q, last_d;
  logic              oor_q, oor_d;

  logic [DigitW-1:0] cur_digit;
  logic [ScaleW-1:0] cur_scale;

  // largest k with k * 10^pos <= rem; compares are independent
  always_comb begin
    cur_digit = '0;
    for (int k = 1; k <= MaxDigit; k++) begin
      if ({{(ScaleW-ValueW){1'b0}}, rem_q} >= digit_scale(pos_q, DigitW'(k))) begin
        cur_digit = DigitW'(k);
      end
    end
    cur_scale = digit_scale(pos_q, cur_digit);
  end

  always_comb begin
    sts_o.range_err  = (rem_q == '0) || (rem_q > MaxValid);
    sts_o.digit_zero = (cur_digit == '0);
    sts_o.sym_last   = ((LenW'(idx_q) + LenW'(1)) == digit_len(digit_q));
    sts_o.rest_zero  = (rem_q == '0);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    rem_d   = rem_q;
    pos_d   = pos_q;
    digit_d = digit_q;
    idx_d   = idx_q;
    if (cmd_i.load) begin
      rem_d = value_i;
      pos_d = PosTop;
    end
    if (cmd_i.extract) begin
      rem_d   = rem_q - cur_scale[ValueW-1:0];
      digit_d = cur_digit;
      idx_d   = '0;
    end
    if (cmd_i.next_pos) pos_d = pos_q - PosW'(1);
    if (cmd_i.next_sym) idx_d = idx_q + IdxW'(1);
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    oor_d       = oor_q;
    if (cmd_i.push_err) begin
      out_valid_d = 1'b1;
      char_d      = ChNone;
      last_d      = 1'b1;
      oor_d       = 1'b1;
    end else if (cmd_i.push_sym) begin
      out_valid_d = 1'b1;
      char_d      = sym_char(pos_q, sym_kind(digit_q, idx_q));
      last_d      = sts_o.sym_last && sts_o.rest_zero;
      oor_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    pos_q   <= pos_d;
    digit_q <= digit_d;
    idx_q   <= idx_d;
    char_q  <= char_d;
    last_q  <= last_d;
    oor_q   <= oor_d;
  end

  assign out_valid_o    = out_valid_q;
  assign symbol_char_o  = char_q;
  assign last_symbol_o  = last_q;
  assign out_of_range_o = oor_q;

`include "integer_to_roman_numeral_encoder_assert.svh"

  `I2R_ASSERT_IMP(a_push_needs_room, cmd_i.push_sym || cmd_i.push_err, sts_o.out_free, "word pushed over a waiting word")
  `I2R_ASSERT_IMP(a_emit_nonzero_digit, cmd_i.push_sym, digit_q != '0, "symbol emitted for a zero digit")
  `I2R_ASSERT_IMP(a_pos_no_underflow, cmd_i.next_pos, pos_q != '0, "position stepped below units")
  `I2R_ASSERT_NXT(a_sym_char_valid, cmd_i.push_sym, char_q != ChNone && !oor_q, "empty symbol emitted")
  `I2R_ASSERT_IMP(a_err_word_shape, out_valid_q && oor_q, last_q && char_q == ChNone, "bad out-of-range word")

endmodule

`default_nettype wire

@@ hw/rtl/integer_to_roman_numeral_encoder.sv @@
// ----------------------------------------------------------------------------
// integer_to_roman_numeral_encoder
// Converts a 12-bit unsigned value to its Roman numeral, one ASCII char
// per output word, thousands first, last word flagged.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  in       input      in_valid_i/in_ready_o  value_i[11:0]
//  out      output     out_valid_o/out_ready_i symbol_char_o[6:0], last_symbol_o,
//                                              out_of_range_o
//
// Sequence: an accept step, then a digit step per decimal position visited
// (digit split-off by a constant compare-and-subtract) and an emit step per
// symbol written to the output register; 3888 visits 4 positions, 15 symbols.
// A value of 0 or above 3999 gives one flagged word.
// Only one value is in flight; in_ready_o is high while the sequencer idles,
// even if the last word still sits in the output register.
// A stalled output holds the sequencer in place; nothing is dropped.
// Reset: asynchronous, active low; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_roman_numeral_encoder
  import i2r_enc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // input words
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ValueW-1:0] value_i,
  // output words
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CharW-1:0]  symbol_char_o,
  output logic              last_symbol_o,
  output logic              out_of_range_o
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // sequencer: idle / split digit / emit symbols
  i2r_enc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // remainder, digit, symbol index and output register
  i2r_enc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .symbol_char_o  (symbol_char_o),
    .last_symbol_o  (last_symbol_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

`default_nettype wire

@@ test/integer_to_roman_numeral_encoder_tb.sv @@
// ----------------------------------------------------------------------------
// integer_to_roman_numeral_encoder_tb
// Feeds values to the Roman numeral encoder and compares every output word
// against a predictor kept inside this bench. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_roman_numeral_encoder_tb;
  import i2r_enc_pkg::*;

  // one expected output word
  typedef struct {
    logic [CharW-1:0] glyph;
    logic             last;
    logic             out_of_range;
  } numeral_word_t;

  // one value waiting to go out; hold_off makes the sender wait until
  // every word already expected has come back
  typedef struct {
    logic [ValueW-1:0] value;
    bit                hold_off;
  } pending_value_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [ValueW-1:0] value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CharW-1:0]  symbol_char_o;
  logic              last_symbol_o;
  logic              out_of_range_o;

  pending_value_t value_q[$];    // values not yet offered
  numeral_word_t  numeral_q[$];  // words predicted, oldest first
  int unsigned    err_count = 0;
  int unsigned    send_gap = 0;
  int unsigned    recv_stall = 0;
  bit             send_calm = 1'b0;
  bit             recv_calm = 1'b0;

  integer_to_roman_numeral_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .symbol_char_o (symbol_char_o),
    .last_symbol_o (last_symbol_o),
    .out_of_range_o(out_of_range_o)
  );

  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  // One line per mismatch, counted.
  task automatic note_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic push_word(input logic [CharW-1:0] glyph, input logic last,
                           input logic out_of_range);
    numeral_word_t w;
    w.glyph        = glyph;
    w.last         = last;
    w.out_of_range = out_of_range;
    numeral_q.push_back(w);
  endtask

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Expected words for one value: thousands first, each digit with its own
  // unit/five/ten symbols; 4 and 9 in subtractive form. Zero and values
  // above 3999 give one flagged word with no symbol.
  task automatic predict_numeral(input logic [ValueW-1:0] v);
    logic [CharW-1:0] run_q[$];
    logic [CharW-1:0] one, five, ten;
    int unsigned      num;
    int unsigned      scale;
    int unsigned      d;
    num = v;
    if (num == 0 || v > MaxValid) begin
      push_word(ChNone, 1'b1, 1'b1);
      return;
    end
    scale = 1000;
    for (int p = 3; p >= 0; p--) begin
      case (p)
        3:       begin one = ChM; five = ChNone; ten = ChNone; end
        2:       begin one = ChC; five = ChD;    ten = ChM;    end
        1:       begin one = ChX; five = ChL;    ten = ChC;    end
        default: begin one = ChI; five = ChV;    ten = ChX;    end
      endcase
      d = (num / scale) % 10;
      if (d == 9) begin
        run_q.push_back(one);
        run_q.push_back(ten);
      end else if (d == 4) begin
        run_q.push_back(one);
        run_q.push_back(five);
      end else begin
        if (d >= 5) begin
          run_q.push_back(five);
          d -= 5;
        end
        for (int j = 0; j < d; j++) run_q.push_back(one);
      end
      scale /= 10;
    end
    for (int i = 0; i < run_q.size(); i++) begin
      push_word(run_q[i], (i == run_q.size() - 1), 1'b0);
    end
  endtask

  task automatic queue_value(input int unsigned v, input bit hold_off);
    pending_value_t pv;
    pv.value    = ValueW'(v);
    pv.hold_off = hold_off;
    value_q.push_back(pv);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued values, predicts on acceptance.
  // A new value goes out only when the slot is free after this edge,
  // so valid stays up with a steady payload until taken.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_i    <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_numeral(value_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (value_q.size() != 0 &&
                     !(value_q[0].hold_off && numeral_q.size() != 0)) begin
          in_valid_i <= 1'b1;
          value_i    <= value_q[0].value;
          value_q.pop_front();
          // occasionally flip into or out of a run with no gaps
          if (($urandom & 31) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : idle_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each accepted word against the oldest prediction,
  // and stalls the output side at random.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : recv_side
    numeral_word_t want;
    bit            took;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      took = out_valid_o && out_ready_i;
      if (took) begin
        if (numeral_q.size() == 0) begin
          note_mismatch($sformatf("word 0x%02h with nothing expected", symbol_char_o));
        end else begin
          want = numeral_q.pop_front();
          if (symbol_char_o !== want.glyph)
            note_mismatch($sformatf("symbol_char 0x%02h, want 0x%02h",
                                    symbol_char_o, want.glyph));
          if (last_symbol_o !== want.last)
            note_mismatch($sformatf("last_symbol %b, want %b (char 0x%02h)",
                                    last_symbol_o, want.last, want.glyph));
          if (out_of_range_o !== want.out_of_range)
            note_mismatch($sformatf("out_of_range %b, want %b",
                                    out_of_range_o, want.out_of_range));
        end
      end
      if (recv_stall != 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (took || $urandom_range(0, 5) == 0) begin
          if (($urandom & 31) == 0) recv_calm = !recv_calm;
          recv_stall = recv_calm ? 0 : idle_len();
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned roll;
    int unsigned v;

    // directed: range edges, every digit form, longest run, bit patterns
    queue_value(0, 1'b0);      // zero rejected
    queue_value(4095, 1'b0);   // all ones, rejected
    queue_value(4000, 1'b0);   // just above range
    queue_value(3999, 1'b0);   // MMMCMXCIX
    queue_value(1, 1'b0);
    queue_value(4, 1'b0);
    queue_value(5, 1'b0);
    queue_value(9, 1'b0);
    queue_value(3888, 1'b0);   // longest numeral, 15 words
    queue_value(1994, 1'b0);
    queue_value(2444, 1'b0);
    queue_value(1000, 1'b0);
    queue_value(3000, 1'b0);
    queue_value(10, 1'b1);     // sender waits for all words first
    queue_value(40, 1'b0);
    queue_value(90, 1'b0);
    queue_value(400, 1'b0);
    queue_value(900, 1'b0);
    queue_value(67, 1'b0);
    queue_value(2730, 1'b0);   // 0xAAA
    queue_value(1365, 1'b0);   // 0x555
    queue_value(2748, 1'b0);   // 0xABC
    queue_value(3276, 1'b0);

    // random: mostly in range, some zero and some too large
    for (int i = 0; i < 150; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 4)       v = 0;
      else if (roll < 14) v = $urandom_range(4000, 4095);
      else if (roll < 24) v = $urandom_range(1, 99);
      else                v = $urandom_range(1, 3999);
      queue_value(v, (i == 75) || ($urandom_range(0, 39) == 0));
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (value_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (numeral_q.size() != 0) @(posedge clk_i);
    // let any stray word show up
    repeat (60) @(posedge clk_i);

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
